// File: hw/rtl/tlds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tuner link deframer with SWR meter.
// Used by tlds_swr_unit and tuner_link_deframer_swr_top; no dependencies.
package tlds_pkg;

    // Meter frame: payload bytes followed by ";;"
    localparam int PAYLOAD_BYTES = 6;
    localparam int WINDOW_DEPTH  = PAYLOAD_BYTES + 1;
    localparam logic [3:0] HEAD_COUNT_MAX  = 4'd15;
    localparam logic [3:0] FRAME_MIN_BYTES = 4'(PAYLOAD_BYTES + 1);

    // Link characters
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_X    = 8'h58;
    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_S    = 8'h53;

    // SWR: cap at 99.9, also forced for reflection coefficient >= 0.999
    localparam logic [14:0] SWR_ONE_Q8 = 15'd256;
    localparam logic [14:0] SWR_CAP_Q8 = 15'd25574;
    localparam logic [19:0] RHO_SCALE  = 20'd1000000;
    localparam logic [19:0] RHO_LIMIT  = 20'd998001;
    localparam logic [4:0]  SQRT_STEPS = 5'd24;
    localparam logic [4:0]  DIV_STEPS  = 5'd26;

    // Result kinds
    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_METER = 2'd1;
    localparam logic [1:0] KIND_TUNE  = 2'd2;

    // Input commands
    localparam logic [2:0] CMD_RX        = 3'd0;
    localparam logic [2:0] CMD_TICK      = 3'd1;
    localparam logic [2:0] CMD_FULL_TUNE = 3'd2;
    localparam logic [2:0] CMD_MEM_TUNE  = 3'd3;
    localparam logic [2:0] CMD_BYPASS    = 3'd4;
    localparam logic [2:0] CMD_AUTO      = 3'd5;
    localparam logic [2:0] CMD_ANTENNA   = 3'd6;
    localparam logic [2:0] CMD_STREAM    = 3'd7;

    // Register map, selected by paddr[2]
    localparam int PADDR_W = 3;
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_WAKE    = 1'b1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
    localparam logic [7:0]  WAKE_RESET    = 8'd32;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] forward_raw;
        logic [15:0] reflected_raw;
        logic [14:0] swr_q8;
        logic        tune_ok;
        logic        last;
    } result_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_TX,
        TS_SWR
    } top_state_t;

    typedef enum logic [3:0] {
        U_IDLE,
        U_MUL_R,
        U_MUL_F,
        U_CMP,
        U_MUL_FR,
        U_SQRT,
        U_NUM,
        U_DIV,
        U_CAP,
        U_DONE
    } unit_state_t;

    function automatic logic [7:0] cmd_letter(input logic [2:0] cmd);
        logic [7:0] letter;
        unique case (cmd)
            CMD_FULL_TUNE: letter = CHAR_F;
            CMD_MEM_TUNE:  letter = CHAR_T;
            CMD_BYPASS:    letter = CHAR_P;
            CMD_AUTO:      letter = CHAR_C;
            CMD_ANTENNA:   letter = CHAR_A;
            CMD_STREAM:    letter = CHAR_S;
            default:       letter = 8'd0;
        endcase
        return letter;
    endfunction

    function automatic result_t result_blank();
        result_t res;
        res.kind          = KIND_TX;
        res.tx_byte       = 8'd0;
        res.forward_raw   = 16'd0;
        res.reflected_raw = 16'd0;
        res.swr_q8        = SWR_ONE_Q8;
        res.tune_ok       = 1'b0;
        res.last          = 1'b0;
        return res;
    endfunction

endpackage

// File: hw/rtl/tuner_link_deframer_swr_top.sv
`timescale 1ns / 1ps
// Top level of the tuner link deframer: command framing, meter deframing,
// tune tracking and APB registers. Uses tlds_pkg and tlds_swr_unit.
//
// Usage:
//   item channel (item_valid/item_stall/item): one command or received byte
//   per transfer. result channel (result_valid/result_stall/result): result
//   transfers, the final one of each item marked by last.
//   APB port: register 0 (0x0) tune timeout in ticks, register 1 (0x4) wake character.
// Sequencing:
//   - Received bytes and ticks are handled on acceptance; a tune-finished result is
//     offered in the cycle after the transfer.
//   - A command item gives three transmit transfers (wake byte, 'X', letter),
//     the first offered the cycle after acceptance, then one per unstalled cycle.
//   - The second ';' of a full meter frame starts the SWR unit: 24 root steps
//     and 26 divide steps through one shared subtractor, plus multiply, compare and
//     cap steps; the meter result is registered once done and the output is free.
//   - item_stall stays high while an item is still being worked off, and
//     whenever the output register holds a result that is being stalled.
// Reset: clears tune state, the byte window and the head count, loads the
//   register reset values and empties the output register.
// Receiver stall: the output register holds its result and the block
//   holds off new items until the result is taken.
module tuner_link_deframer_swr_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  tlds_pkg::item_t              item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output tlds_pkg::result_t            result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tlds_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tlds_pkg::*;

    top_state_t  state_reg, state_next;
    logic        tune_busy_reg, tune_busy_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [3:0]  head_count_reg, head_count_next;
    logic        prev_semi_reg, prev_semi_next;
    logic        tx_step_reg, tx_step_next;
    logic [7:0]  letter_reg, letter_next;
    logic [7:0]  window_reg [WINDOW_DEPTH];
    logic        shift_en;

    logic [15:0] cfg_timeout_reg;
    logic [7:0]  cfg_wake_reg;
    logic        cfg_we;

    logic        result_valid_reg;
    result_t     result_reg, result_next;
    logic        result_load;
    logic        out_free;
    logic        item_acc;

    logic        unit_start;
    logic        unit_done;
    logic [14:0] unit_swr;
    logic [15:0] frame_fwd, frame_ref;

    // Output slot is free when empty or being taken this cycle
    assign out_free   = ~result_valid_reg | ~result_stall;
    assign item_stall = ~((state_reg == TS_IDLE) & out_free);
    assign item_acc   = item_valid & ~item_stall;

    assign frame_fwd = {window_reg[0], window_reg[1]};
    assign frame_ref = {window_reg[2], window_reg[3]};

    tlds_swr_unit u_swr (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .fwd   (frame_fwd),
        .refl  (frame_ref),
        .done  (unit_done),
        .swr   (unit_swr)
    );

    // APB registers
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_timeout_reg <= TIMEOUT_RESET;
            cfg_wake_reg    <= WAKE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[2])
                REG_TIMEOUT: cfg_timeout_reg <= pwdata[15:0];
                REG_WAKE:    cfg_wake_reg    <= pwdata[7:0];
                default:     cfg_wake_reg    <= cfg_wake_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TIMEOUT: prdata = {16'd0, cfg_timeout_reg};
            REG_WAKE:    prdata = {24'd0, cfg_wake_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= TS_IDLE;
            tune_busy_reg    <= 1'b0;
            timeout_reg      <= 16'd0;
            head_count_reg   <= 4'd0;
            prev_semi_reg    <= 1'b0;
            tx_step_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                window_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg      <= state_next;
            tune_busy_reg  <= tune_busy_next;
            timeout_reg    <= timeout_next;
            head_count_reg <= head_count_next;
            prev_semi_reg  <= prev_semi_next;
            tx_step_reg    <= tx_step_next;
            if (result_load)
                result_valid_reg <= 1'b1;
            else if (out_free)
                result_valid_reg <= 1'b0;
            // Advance the byte window; the newest byte enters at the top
            if (shift_en)
            begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++)
                    window_reg[i] <= window_reg[i + 1];
                window_reg[WINDOW_DEPTH - 1] <= item.rx_byte;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
        if (result_load)
            result_reg <= result_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        tune_busy_next  = tune_busy_reg;
        timeout_next    = timeout_reg;
        head_count_next = head_count_reg;
        prev_semi_next  = prev_semi_reg;
        tx_step_next    = tx_step_reg;
        letter_next     = letter_reg;
        shift_en        = 1'b0;
        unit_start      = 1'b0;
        result_load     = 1'b0;
        result_next     = result_blank();

        unique case (state_reg)
            TS_IDLE:
            begin
                if (item_acc)
                begin
                    unique case (item.command) inside
                        CMD_RX:
                        begin
                            if (tune_busy_reg && head_count_reg == 4'd0 && item.rx_byte[7])
                            begin
                                // Tune status byte at the head of the stream
                                tune_busy_next      = 1'b0;
                                timeout_next        = 16'd0;
                                result_load         = 1'b1;
                                result_next.kind    = KIND_TUNE;
                                result_next.tune_ok = item.rx_byte[0];
                                result_next.last    = 1'b1;
                            end
                            else if (item.rx_byte == CHAR_SEMI && prev_semi_reg)
                            begin
                                // Frame end; short frames are dropped
                                if (head_count_reg >= FRAME_MIN_BYTES)
                                begin
                                    unit_start = 1'b1;
                                    state_next = TS_SWR;
                                end
                                head_count_next = 4'd0;
                                prev_semi_next  = 1'b0;
                            end
                            else
                            begin
                                shift_en = 1'b1;
                                if (head_count_reg != HEAD_COUNT_MAX)
                                    head_count_next = head_count_reg + 4'd1;
                                prev_semi_next = (item.rx_byte == CHAR_SEMI);
                            end
                        end
                        CMD_TICK:
                        begin
                            if (tune_busy_reg)
                            begin
                                if (timeout_reg <= 16'd1)
                                begin
                                    timeout_next     = 16'd0;
                                    tune_busy_next   = 1'b0;
                                    result_load      = 1'b1;
                                    result_next.kind = KIND_TUNE;
                                    result_next.last = 1'b1;
                                end
                                else
                                begin
                                    timeout_next = timeout_reg - 16'd1;
                                end
                            end
                        end
                        default:
                        begin
                            // Command sequence: wake byte first
                            if (item.command == CMD_FULL_TUNE || item.command == CMD_MEM_TUNE)
                            begin
                                tune_busy_next = 1'b1;
                                timeout_next   = cfg_timeout_reg;
                            end
                            letter_next         = cmd_letter(item.command);
                            tx_step_next        = 1'b0;
                            result_load         = 1'b1;
                            result_next.tx_byte = cfg_wake_reg;
                            state_next          = TS_TX;
                        end
                    endcase
                end
            end
            TS_TX:
            begin
                if (out_free)
                begin
                    result_load         = 1'b1;
                    result_next.tx_byte = tx_step_reg ? letter_reg : CHAR_X;
                    result_next.last    = tx_step_reg;
                    tx_step_next        = 1'b1;
                    if (tx_step_reg)
                        state_next = TS_IDLE;
                end
            end
            TS_SWR:
            begin
                if (unit_done && out_free)
                begin
                    result_load               = 1'b1;
                    result_next.kind          = KIND_METER;
                    result_next.forward_raw   = frame_fwd;
                    result_next.reflected_raw = frame_ref;
                    result_next.swr_q8        = unit_swr;
                    result_next.last          = 1'b1;
                    state_next                = TS_IDLE;
                end
            end
            default:
            begin
                state_next = TS_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // A tune command arms the timeout from the register
    a_tune_arms: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && (item.command == CMD_FULL_TUNE || item.command == CMD_MEM_TUNE)
        |=> tune_busy_reg && timeout_reg == $past(cfg_timeout_reg))
        else $error("tune command did not arm the timeout");

    // An idle tuner never holds a running timeout
    a_idle_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        !tune_busy_reg |-> timeout_reg == 16'd0)
        else $error("timeout left running while not tuning");

    // Meter readings stay within 1.0 and the cap
    a_swr_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.kind == KIND_METER
        |-> result_reg.swr_q8 >= SWR_ONE_Q8 && result_reg.swr_q8 <= SWR_CAP_Q8)
        else $error("meter SWR out of range");

    // Meter and tune results are always the last of their item
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.kind != KIND_TX |-> result_reg.last)
        else $error("single result not marked last");
`endif

endmodule

// File: hw/rtl/tlds_swr_unit.sv
`timescale 1ns / 1ps
// Iterative SWR unit: one 16x20 multiplier and one shared subtract/compare
// serve the cap test, the bit-serial square root and the restoring divide. Uses tlds_pkg.
module tlds_swr_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] fwd,
    input  logic [15:0] refl,
    output logic        done,
    output logic [14:0] swr
);
    import tlds_pkg::*;

    unit_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic [15:0] f_reg, r_reg, den_reg;
    logic [35:0] prod_reg, lhs_reg;
    logic [47:0] rad_reg;
    logic [23:0] root_reg;
    logic [26:0] rem_reg;
    logic [25:0] num_reg, quo_reg;
    logic [14:0] swr_reg;

    logic [15:0] mul_a;
    logic [19:0] mul_b;
    logic [35:0] mul_p;
    logic [35:0] sub_a, sub_b;
    logic [36:0] sub_d;
    logic        sub_ge;
    logic [26:0] sq_a, sq_b;
    logic [16:0] dv_a, dv_b;
    logic [16:0] sum_fr;

    // Shared multiplier
    always_comb
    begin
        mul_a = 16'd0;
        mul_b = 20'd0;
        unique case (state_reg)
            U_MUL_R:
            begin
                mul_a = r_reg;
                mul_b = RHO_SCALE;
            end
            U_MUL_F:
            begin
                mul_a = f_reg;
                mul_b = RHO_LIMIT;
            end
            U_MUL_FR:
            begin
                mul_a = f_reg;
                mul_b = {4'd0, r_reg};
            end
            default:
            begin
                mul_a = 16'd0;
                mul_b = 20'd0;
            end
        endcase
    end

    assign mul_p = {20'd0, mul_a} * {16'd0, mul_b};

    // Shared subtract/compare
    assign sq_a = {rem_reg[24:0], rad_reg[47:46]};
    assign sq_b = {1'b0, root_reg, 2'b01};
    assign dv_a = {rem_reg[15:0], num_reg[25]};
    assign dv_b = {1'b0, den_reg};

    always_comb
    begin
        sub_a = 36'd0;
        sub_b = 36'd0;
        unique case (state_reg)
            U_CMP:
            begin
                sub_a = lhs_reg;
                sub_b = prod_reg;
            end
            U_SQRT:
            begin
                sub_a = {9'd0, sq_a};
                sub_b = {9'd0, sq_b};
            end
            U_DIV:
            begin
                sub_a = {19'd0, dv_a};
                sub_b = {19'd0, dv_b};
            end
            U_CAP:
            begin
                sub_a = {21'd0, SWR_CAP_Q8};
                sub_b = {10'd0, quo_reg};
            end
            default:
            begin
                sub_a = 36'd0;
                sub_b = 36'd0;
            end
        endcase
    end

    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = ~sub_d[36];
    assign sum_fr = {1'b0, f_reg} + {1'b0, r_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            U_IDLE, U_DONE:
            begin
                if (start)
                    state_next = U_MUL_R;
            end
            U_MUL_R:  state_next = (f_reg == 16'd0) ? U_DONE : U_MUL_F;
            U_MUL_F:  state_next = U_CMP;
            U_CMP:    state_next = sub_ge ? U_DONE : U_MUL_FR;
            U_MUL_FR:
            begin
                state_next = U_SQRT;
                cnt_next   = 5'd0;
            end
            U_SQRT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == SQRT_STEPS - 5'd1)
                    state_next = U_NUM;
            end
            U_NUM:
            begin
                state_next = U_DIV;
                cnt_next   = 5'd0;
            end
            U_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_STEPS - 5'd1)
                    state_next = U_CAP;
            end
            U_CAP:    state_next = U_DONE;
            default:  state_next = U_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            U_IDLE, U_DONE:
            begin
                if (start)
                begin
                    f_reg <= fwd;
                    r_reg <= refl;
                end
            end
            U_MUL_R:
            begin
                prod_reg <= mul_p;
                if (f_reg == 16'd0)
                    swr_reg <= SWR_ONE_Q8;
            end
            U_MUL_F:
            begin
                lhs_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            U_CMP:
            begin
                if (sub_ge)
                    swr_reg <= SWR_CAP_Q8;
                root_reg <= 24'd0;
                rem_reg  <= 27'd0;
            end
            U_MUL_FR:
            begin
                rad_reg <= {mul_p[31:0], 16'd0};
            end
            U_SQRT:
            begin
                rad_reg <= {rad_reg[45:0], 2'b00};
                if (sub_ge)
                begin
                    rem_reg  <= sub_d[26:0];
                    root_reg <= {root_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sq_a;
                    root_reg <= {root_reg[22:0], 1'b0};
                end
            end
            U_NUM:
            begin
                num_reg <= {1'b0, sum_fr, 8'd0} + {1'b0, root_reg, 1'b0};
                den_reg <= f_reg - r_reg;
                rem_reg <= 27'd0;
                quo_reg <= 26'd0;
            end
            U_DIV:
            begin
                num_reg <= {num_reg[24:0], 1'b0};
                if (sub_ge)
                begin
                    rem_reg <= {10'd0, sub_d[16:0]};
                    quo_reg <= {quo_reg[24:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {10'd0, dv_a};
                    quo_reg <= {quo_reg[24:0], 1'b0};
                end
            end
            U_CAP:
            begin
                swr_reg <= sub_ge ? quo_reg[14:0] : SWR_CAP_Q8;
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == U_DONE);
    assign swr  = swr_reg;

endmodule

// File: bench/tuner_link_checker.sv
`timescale 1ns / 1ps
// Result checker for the tuner link deframer: watches the item, result and APB ports,
// forecasts every result the block owes and compares each delivered one in order.
// Depends on tlds_pkg for the item and result types, codes and link characters.
module tuner_link_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_stall,
    input  tlds_pkg::item_t              item,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  tlds_pkg::result_t            result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [tlds_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output int                           mismatches,
    output int                           outstanding
);
    import tlds_pkg::*;

    localparam int PRINT_LIMIT = 60;

    result_t     awaited_results[$];
    logic [15:0] timeout_setting;
    logic [7:0]  wake_setting;
    logic [7:0]  byte_window [WINDOW_DEPTH];
    logic [3:0]  head_count;
    logic        semi_seen;
    logic        tune_running;
    logic [15:0] tune_countdown;
    int          error_count = 0;
    int          result_index = 0;

    assign mismatches = error_count;

    task automatic report(string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Q7.8 SWR from forward/reflected raw values, exact integer form
    function automatic logic [14:0] swr_ratio(logic [15:0] fwd, logic [15:0] refl);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        longint unsigned num;
        longint unsigned quot;
        if (fwd == 16'd0)
            return SWR_ONE_Q8;
        if (64'(refl) * 64'(RHO_SCALE) >= 64'(fwd) * 64'(RHO_LIMIT))
            return SWR_CAP_Q8;
        rem   = (64'(fwd) * 64'(refl)) << 16;
        root  = 64'd0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 64'd0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        num  = (64'(fwd) + 64'(refl)) * 64'd256 + 64'd2 * root;
        quot = num / 64'(fwd - refl);
        return (quot > 64'(SWR_CAP_Q8)) ? SWR_CAP_Q8 : quot[14:0];
    endfunction

    function automatic result_t make_result(logic [1:0] kind, logic [7:0] tx,
                                            logic [15:0] fwd, logic [15:0] refl,
                                            logic [14:0] swr, logic ok, logic fin);
        result_t res;
        res.kind          = kind;
        res.tx_byte       = tx;
        res.forward_raw   = fwd;
        res.reflected_raw = refl;
        res.swr_q8        = swr;
        res.tune_ok       = ok;
        res.last          = fin;
        return res;
    endfunction

    task automatic forecast_results(item_t it);
        logic [7:0]  letter;
        logic [15:0] fwd;
        logic [15:0] refl;
        if (it.command == CMD_RX)
        begin
            if (tune_running && head_count == 4'd0 && it.rx_byte[7])
            begin
                tune_running   = 1'b0;
                tune_countdown = 16'd0;
                awaited_results.push_back(make_result(KIND_TUNE, 8'd0, 16'd0, 16'd0,
                                                      SWR_ONE_Q8, it.rx_byte[0], 1'b1));
            end
            else if (it.rx_byte == CHAR_SEMI && semi_seen)
            begin
                if (head_count >= FRAME_MIN_BYTES)
                begin
                    fwd  = {byte_window[0], byte_window[1]};
                    refl = {byte_window[2], byte_window[3]};
                    awaited_results.push_back(make_result(KIND_METER, 8'd0, fwd, refl,
                                                          swr_ratio(fwd, refl), 1'b0, 1'b1));
                end
                head_count = 4'd0;
                semi_seen  = 1'b0;
            end
            else
            begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++)
                    byte_window[i] = byte_window[i + 1];
                byte_window[WINDOW_DEPTH - 1] = it.rx_byte;
                if (head_count < HEAD_COUNT_MAX)
                    head_count = head_count + 4'd1;
                semi_seen = (it.rx_byte == CHAR_SEMI);
            end
        end
        else if (it.command == CMD_TICK)
        begin
            if (tune_running)
            begin
                if (tune_countdown <= 16'd1)
                begin
                    tune_countdown = 16'd0;
                    tune_running   = 1'b0;
                    awaited_results.push_back(make_result(KIND_TUNE, 8'd0, 16'd0, 16'd0,
                                                          SWR_ONE_Q8, 1'b0, 1'b1));
                end
                else
                begin
                    tune_countdown = tune_countdown - 16'd1;
                end
            end
        end
        else
        begin
            case (it.command)
                CMD_FULL_TUNE: letter = CHAR_F;
                CMD_MEM_TUNE:  letter = CHAR_T;
                CMD_BYPASS:    letter = CHAR_P;
                CMD_AUTO:      letter = CHAR_C;
                CMD_ANTENNA:   letter = CHAR_A;
                default:       letter = CHAR_S;
            endcase
            if (it.command == CMD_FULL_TUNE || it.command == CMD_MEM_TUNE)
            begin
                tune_running   = 1'b1;
                tune_countdown = timeout_setting;
            end
            awaited_results.push_back(make_result(KIND_TX, wake_setting, 16'd0, 16'd0,
                                                  SWR_ONE_Q8, 1'b0, 1'b0));
            awaited_results.push_back(make_result(KIND_TX, CHAR_X, 16'd0, 16'd0,
                                                  SWR_ONE_Q8, 1'b0, 1'b0));
            awaited_results.push_back(make_result(KIND_TX, letter, 16'd0, 16'd0,
                                                  SWR_ONE_Q8, 1'b0, 1'b1));
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            awaited_results.delete();
            timeout_setting = TIMEOUT_RESET;
            wake_setting    = WAKE_RESET;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                byte_window[i] = 8'd0;
            head_count     = 4'd0;
            semi_seen      = 1'b0;
            tune_running   = 1'b0;
            tune_countdown = 16'd0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_TIMEOUT)
                    timeout_setting = pwdata[15:0];
                else
                    wake_setting = pwdata[7:0];
            end
            // Results first: a result on this edge never belongs to an item taken on it
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    report($sformatf("result %0d arrived with nothing awaited", result_index));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.kind !== want.kind || result.tx_byte !== want.tx_byte ||
                        result.forward_raw !== want.forward_raw ||
                        result.reflected_raw !== want.reflected_raw ||
                        result.swr_q8 !== want.swr_q8 || result.tune_ok !== want.tune_ok ||
                        result.last !== want.last)
                        report($sformatf({"result %0d: got kind=%0d tx=%h fwd=%h ref=%h ",
                                          "swr=%0d ok=%b last=%b, want kind=%0d tx=%h ",
                                          "fwd=%h ref=%h swr=%0d ok=%b last=%b"},
                                         result_index, result.kind, result.tx_byte,
                                         result.forward_raw, result.reflected_raw,
                                         result.swr_q8, result.tune_ok, result.last,
                                         want.kind, want.tx_byte, want.forward_raw,
                                         want.reflected_raw, want.swr_q8, want.tune_ok,
                                         want.last));
                end
                result_index++;
            end
            if (item_valid && !item_stall)
                forecast_results(item);
        end
        outstanding <= awaited_results.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the tuner link deframer bench: clock, reset, item and APB stimulus,
// random receiver stalls and the verdict. Depends on tlds_pkg, the block and
// tuner_link_checker, which does all forecasting and comparing.
module testbench;
    import tlds_pkg::*;

    // Watchdog limit; give the slowest legal run plenty of room
    localparam int CYCLE_LIMIT   = 400000;
    // Settle time, longer than an SWR unit run plus output
    localparam int SETTLE_CYCLES = 80;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    item_t              item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    result_t            result;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int items_sent        = 0;
    int cycle_count       = 0;
    int mismatches;
    int outstanding;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    tuner_link_deframer_swr_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    tuner_link_checker link_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Receiver side: stall at random, rate set by the current phase
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Watchdog: a hung handshake or a lost result ends up here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one item and hold it until the transfer happens. Idle cycles
    // drop valid before the item is shown, never while it is being stalled.
    task automatic send_item(logic [2:0] cmd, logic [7:0] data);
        item_t next_item;
        next_item.command = cmd;
        next_item.rx_byte = data;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= next_item;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        items_sent++;
    endtask

    task automatic send_semis(int count);
        repeat (count)
            send_item(CMD_RX, CHAR_SEMI);
    endtask

    // Stray bytes; semicolons show up often enough to break frames early
    task automatic send_noise(int count);
        repeat (count)
            send_item(CMD_RX, ($urandom_range(7) == 0) ? CHAR_SEMI : 8'($urandom));
    endtask

    // Well-formed meter frame: six payload bytes, then ";;". Bias the two
    // raw values toward zero forward power, the 0.999 cap edge and small values.
    task automatic send_meter_frame();
        logic [15:0] fwd;
        logic [15:0] refl;
        fwd  = 16'($urandom);
        refl = 16'($urandom);
        case ($urandom_range(5))
            0: fwd = 16'd0;
            1: refl = fwd - 16'($urandom_range(40));
            2: refl = 16'd0;
            3:
            begin
                fwd  = 16'($urandom_range(255));
                refl = 16'($urandom_range(255));
            end
            4: refl = fwd >> $urandom_range(1, 8);
            default: ;
        endcase
        send_item(CMD_RX, fwd[15:8]);
        send_item(CMD_RX, fwd[7:0]);
        send_item(CMD_RX, refl[15:8]);
        send_item(CMD_RX, refl[7:0]);
        send_item(CMD_RX, 8'($urandom));
        send_item(CMD_RX, 8'($urandom));
        send_semis(2);
    endtask

    // Mix: mostly frames, then commands, tick bursts, tune replies, noise
    // and frames of the wrong length (short ones and over-long streams).
    task automatic run_random(int item_mark);
        int pick;
        while (items_sent < item_mark)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_meter_frame();
            else if (pick < 55)
                send_item(3'($urandom_range(CMD_FULL_TUNE, CMD_STREAM)), 8'($urandom));
            else if (pick < 70)
                repeat ($urandom_range(1, 6))
                    send_item(CMD_TICK, 8'($urandom));
            else if (pick < 80)
                send_item(CMD_RX, 8'h80 | 8'($urandom));
            else if (pick < 90)
                send_noise($urandom_range(1, 3));
            else
            begin
                send_noise($urandom_range(0, 18));
                send_semis(2);
            end
        end
    endtask

    // Drop valid, wait out every awaited result, then let the block settle
    task automatic drain_link();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen
    task automatic apb_write(logic reg_sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one idling: sender 29 of 100, receiver 45 of 100
        sender_idle_pct   = 29;
        receiver_idle_pct = 45;

        // Directed: every command at reset settings; memory tune reloads the
        // timeout while busy, and the rx field of a command is ignored
        send_item(CMD_FULL_TUNE, 8'h00);
        send_item(CMD_MEM_TUNE, 8'hFF);
        send_item(CMD_BYPASS, 8'h00);
        send_item(CMD_AUTO, 8'hFF);
        send_item(CMD_ANTENNA, 8'h00);
        send_item(CMD_STREAM, 8'hFF);
        // Tune reply at the head of the stream, success bit set
        send_item(CMD_RX, 8'h81);
        // Tick while no tune runs: no effect
        send_item(CMD_TICK, 8'hFF);
        // Full frame at the raw extremes: forward 0xFFFF, reflected 0
        send_item(CMD_RX, 8'hFF);
        send_item(CMD_RX, 8'hFF);
        send_item(CMD_RX, 8'h00);
        send_item(CMD_RX, 8'h00);
        send_item(CMD_RX, 8'h00);
        send_item(CMD_RX, 8'hFF);
        send_semis(2);
        // Third semicolon opens a new stream, the fourth closes a short frame
        send_semis(2);
        // Busy: bit 7 clear at the head and bit 7 set past the head both go
        // into the window; a short frame resets the head, then a failed reply
        send_item(CMD_FULL_TUNE, 8'h00);
        send_item(CMD_RX, 8'h7F);
        send_item(CMD_RX, 8'h80);
        send_semis(2);
        send_item(CMD_RX, 8'hFE);

        // Hold the sender until everything has come back, then move the
        // registers to their low extremes
        drain_link();
        apb_write(REG_TIMEOUT, {16'($urandom), 16'd1});
        apb_write(REG_WAKE, {24'($urandom), 8'h00});
        run_random(90);
        drain_link();
        run_random(160);

        // Phase two: idling swapped, registers at their high extremes
        drain_link();
        apb_write(REG_TIMEOUT, {16'($urandom), 16'hFFFF});
        apb_write(REG_WAKE, {24'($urandom), 8'hFF});
        sender_idle_pct   = 45;
        receiver_idle_pct = 29;
        run_random(300);

        // Phase three: no idling, short timeout so tick bursts expire tunes
        drain_link();
        apb_write(REG_TIMEOUT, {16'($urandom), 16'd4});
        apb_write(REG_WAKE, {24'($urandom), 8'hA5});
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random(420);

        drain_link();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tlds_pkg.sv
hw/rtl/tlds_swr_unit.sv
hw/rtl/tuner_link_deframer_swr_top.sv
bench/tuner_link_checker.sv
bench/testbench.sv
